// File: hw/rtl/mliqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mliqe_pkg: shared definitions for the multi-list index queue engine
// Field widths, parameter defaults and operation codes.
// ----------------------------------------------------------------------------
package mliqe_pkg;

	localparam int OP_W   = 2;
	localparam int LIST_W = 4;
	localparam int NODE_W = 6;

	localparam int NODES_DEF     = 64;
	localparam int RUN_LISTS_DEF = 8;
	localparam int LISTS_DEF     = 16;

	// The per-processor run lists start at this list index.
	localparam int FIRST_RUN_LIST = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_STEAL  = 2'd3
	} op_t;

endpackage
`default_nettype wire

// File: hw/rtl/multi_list_index_queue_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_list_index_queue_engine: linked-list multi-queue manager
// Keeps LISTS singly linked lists threaded through one shared link table.
// ----------------------------------------------------------------------------
// Usage: one input word (op, list_id, node) is taken on the in_valid/in_ready
// handshake, and exactly one result word (node_out, hit, list_out) leaves on
// the out_valid/out_ready handshake for each input word, in order.
// The block handles one word at a time. Both the list heads and the node
// links live in synchronous memories with one read port and one write port
// and a registered read, and every link of a chain costs one read.
// Pop reads the list head and then the head node's link, and writes both
// tables; steal does the same on the first nonempty run list, skipping
// empty run lists in order, and misses when every run list is empty.
// Push walks the list from its head to the tail and links the node there;
// remove walks the list to the node and links its predecessor past it.
// A word with an out-of-range list or node goes straight to its result.
// The result sits in an output register, so a new input word is taken while
// an earlier result still waits for out_ready. When the receiver stalls and
// the output register is still full, the finished word waits in the engine
// and in_ready stays low until the output register empties.
// After reset the engine runs an initialization pass that rebuilds list 0
// as every node in index order and empties all other lists; in_ready stays
// low during that pass.
// ----------------------------------------------------------------------------
module multi_list_index_queue_engine #(
	parameter int NODES     = mliqe_pkg::NODES_DEF,
	parameter int RUN_LISTS = mliqe_pkg::RUN_LISTS_DEF,
	parameter int LISTS     = mliqe_pkg::LISTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mliqe_pkg::OP_W-1:0]    op,
	input  wire logic [mliqe_pkg::LIST_W-1:0]  list_id,
	input  wire logic [mliqe_pkg::NODE_W-1:0]  node,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mliqe_pkg::NODE_W-1:0]       node_out,
	output logic                               hit,
	output logic [mliqe_pkg::LIST_W-1:0]       list_out
);

	// Node index width, list index width, walk step counter width.
	localparam int NW   = $clog2(NODES);
	localparam int LW   = $clog2(LISTS);
	localparam int SCW  = $clog2(NODES + 1);
	// The initialization pass covers the deeper of the two memories.
	localparam int MAXD = (NODES > LISTS) ? NODES : LISTS;
	localparam int IW   = $clog2(MAXD);
	localparam int LAST_RUN = mliqe_pkg::FIRST_RUN_LIST + RUN_LISTS - 1;

	// A link is a valid bit on top of a node index.
	typedef logic [NW:0] link_t;

	typedef enum logic [9:0] {
		S_INIT  = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_PUSH  = 10'b00_0000_0100,
		S_POP   = 10'b00_0000_1000,
		S_POP2  = 10'b00_0001_0000,
		S_STEAL = 10'b00_0010_0000,
		S_REM   = 10'b00_0100_0000,
		S_REM2  = 10'b00_1000_0000,
		S_CLR   = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] init_q, init_d;

	// Per-word working registers.
	logic [NW-1:0]                  nd_q, nd_d;
	logic [NW-1:0]                  cur_q, cur_d;
	logic [SCW-1:0]                 steps_q, steps_d;
	logic                           at_head_q, at_head_d;
	logic [mliqe_pkg::LIST_W-1:0]   sl_q, sl_d;
	logic [LW-1:0]                  pl_q, pl_d;
	logic [NW-1:0]                  taken_q, taken_d;
	logic                           hit_q, hit_d;
	logic [mliqe_pkg::LIST_W-1:0]   lo_q, lo_d;

	// Output register.
	logic                           out_valid_q;
	logic [mliqe_pkg::NODE_W-1:0]   node_out_q;
	logic                           hit_out_q;
	logic [mliqe_pkg::LIST_W-1:0]   list_out_q;
	logic                           load_out;

	// Memory ports.
	link_t         head_mem [LISTS];
	link_t         next_mem [NODES];
	link_t         hd_rd_q, nx_rd_q;
	logic [LW-1:0] hd_raddr, hd_waddr;
	logic [NW-1:0] nx_raddr, nx_waddr;
	link_t         hd_wdata, nx_wdata;
	logic          hd_we, nx_we;

	// The link under inspection comes from the head table on the first step
	// of a walk and from the node link table afterwards.
	link_t         link_cur;
	logic          lv;
	logic [NW-1:0] li;
	logic          lst_ok, nd_ok, steal_last;

	assign link_cur = at_head_q ? hd_rd_q : nx_rd_q;
	assign lv       = link_cur[NW];
	assign li       = link_cur[NW-1:0];
	assign lst_ok   = 32'(list_id) < LISTS;
	assign nd_ok    = 32'(node) < NODES;
	// The steal scan ends at the last run list or at the last list held.
	assign steal_last = (32'(sl_q) == LAST_RUN) || (32'(sl_q) + 1 >= LISTS);

	always_comb begin
		state_d   = state_q;
		init_d    = init_q;
		nd_d      = nd_q;
		cur_d     = cur_q;
		steps_d   = steps_q;
		at_head_d = at_head_q;
		sl_d      = sl_q;
		pl_d      = pl_q;
		taken_d   = taken_q;
		hit_d     = hit_q;
		lo_d      = lo_q;
		in_ready  = 1'b0;
		load_out  = 1'b0;
		hd_raddr  = pl_q;
		nx_raddr  = cur_q;
		hd_we     = 1'b0;
		hd_waddr  = pl_q;
		hd_wdata  = '0;
		nx_we     = 1'b0;
		nx_waddr  = cur_q;
		nx_wdata  = '0;

		unique case (state_q)
			S_INIT: begin
				hd_we    = 32'(init_q) < LISTS;
				hd_waddr = LW'(init_q);
				hd_wdata = {init_q == '0, NW'(0)};
				nx_we    = 32'(init_q) < NODES;
				nx_waddr = NW'(init_q);
				if (32'(init_q) + 1 < NODES) begin
					nx_wdata = {1'b1, NW'(init_q + IW'(1))};
				end
				if (init_q == IW'(MAXD - 1)) begin
					state_d = S_IDLE;
				end else begin
					init_d = init_q + IW'(1);
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				hd_raddr = (mliqe_pkg::op_t'(op) == mliqe_pkg::OP_STEAL)
					? LW'(mliqe_pkg::FIRST_RUN_LIST) : LW'(list_id);
				if (in_valid) begin
					nd_d      = NW'(node);
					taken_d   = '0;
					hit_d     = 1'b0;
					lo_d      = list_id;
					pl_d      = LW'(list_id);
					at_head_d = 1'b1;
					steps_d   = '0;
					sl_d      = mliqe_pkg::LIST_W'(mliqe_pkg::FIRST_RUN_LIST);
					unique case (mliqe_pkg::op_t'(op))
						mliqe_pkg::OP_PUSH:   state_d = (lst_ok && nd_ok) ? S_PUSH : S_DONE;
						mliqe_pkg::OP_POP:    state_d = lst_ok ? S_POP : S_DONE;
						mliqe_pkg::OP_REMOVE: state_d = (lst_ok && nd_ok) ? S_REM : S_DONE;
						mliqe_pkg::OP_STEAL:  state_d = S_STEAL;
						default:              state_d = S_DONE;
					endcase
				end
			end
			S_PUSH: begin
				if (!lv) begin
					if (at_head_q) begin
						hd_we    = 1'b1;
						hd_wdata = {1'b1, nd_q};
						nx_we    = 1'b1;
						nx_waddr = nd_q;
						hit_d    = 1'b1;
						state_d  = S_DONE;
					end else begin
						nx_we    = 1'b1;
						nx_wdata = {1'b1, nd_q};
						state_d  = S_CLR;
					end
				end else if (steps_q == SCW'(NODES)) begin
					state_d = S_DONE;
				end else begin
					cur_d     = li;
					nx_raddr  = li;
					steps_d   = steps_q + SCW'(1);
					at_head_d = 1'b0;
				end
			end
			S_POP: begin
				if (!hd_rd_q[NW]) begin
					state_d = S_DONE;
				end else begin
					taken_d  = hd_rd_q[NW-1:0];
					nx_raddr = hd_rd_q[NW-1:0];
					state_d  = S_POP2;
				end
			end
			S_STEAL: begin
				if (hd_rd_q[NW]) begin
					taken_d  = hd_rd_q[NW-1:0];
					nx_raddr = hd_rd_q[NW-1:0];
					lo_d     = sl_q;
					pl_d     = LW'(sl_q);
					state_d  = S_POP2;
				end else if (steal_last) begin
					state_d = S_DONE;
				end else begin
					sl_d     = sl_q + mliqe_pkg::LIST_W'(1);
					hd_raddr = LW'(sl_q + mliqe_pkg::LIST_W'(1));
				end
			end
			S_POP2: begin
				hd_we    = 1'b1;
				hd_wdata = nx_rd_q;
				nx_we    = 1'b1;
				nx_waddr = taken_q;
				hit_d    = 1'b1;
				state_d  = S_DONE;
			end
			S_REM: begin
				if (!lv) begin
					state_d = S_DONE;
				end else if (li == nd_q) begin
					nx_raddr = nd_q;
					state_d  = S_REM2;
				end else if (steps_q == SCW'(NODES - 1)) begin
					state_d = S_DONE;
				end else begin
					cur_d     = li;
					nx_raddr  = li;
					steps_d   = steps_q + SCW'(1);
					at_head_d = 1'b0;
				end
			end
			S_REM2: begin
				if (at_head_q) begin
					hd_we    = 1'b1;
					hd_wdata = nx_rd_q;
					nx_we    = 1'b1;
					nx_waddr = nd_q;
					hit_d    = 1'b1;
					state_d  = S_DONE;
				end else begin
					nx_we    = 1'b1;
					nx_wdata = nx_rd_q;
					state_d  = S_CLR;
				end
			end
			S_CLR: begin
				// The node's own link is cleared after its predecessor is patched.
				nx_we    = 1'b1;
				nx_waddr = nd_q;
				hit_d    = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		nd_q      <= nd_d;
		cur_q     <= cur_d;
		steps_q   <= steps_d;
		at_head_q <= at_head_d;
		sl_q      <= sl_d;
		pl_q      <= pl_d;
		taken_q   <= taken_d;
		hit_q     <= hit_d;
		lo_q      <= lo_d;
		if (load_out) begin
			node_out_q <= mliqe_pkg::NODE_W'(taken_q);
			hit_out_q  <= hit_q;
			list_out_q <= lo_q;
		end
	end

	// Head table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (hd_we) begin
			head_mem[hd_waddr] <= hd_wdata;
		end
		hd_rd_q <= head_mem[hd_raddr];
	end

	// Node link table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		nx_rd_q <= next_mem[nx_raddr];
	end

	assign out_valid = out_valid_q;
	assign node_out  = node_out_q;
	assign hit       = hit_out_q;
	assign list_out  = list_out_q;

endmodule
`default_nettype wire

// File: hw/rtl/mliqe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mliqe_checker: port-level assertions for the queue engine
// Watches the handshakes and result words of the top level.
// ----------------------------------------------------------------------------
module mliqe_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [mliqe_pkg::NODE_W-1:0]  node_out,
	input wire logic                          hit,
	input wire logic [mliqe_pkg::LIST_W-1:0]  list_out
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_out) && $stable(hit)
			&& $stable(list_out))
		else $error("result word changed while stalled");

	// A miss never reports a node.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> node_out == '0)
		else $error("miss reported a nonzero node");

	// Words are handled one at a time: the engine is busy after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	// A result appears in the same cycle the engine returns to waiting.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while the engine was still busy");

endmodule

bind multi_list_index_queue_engine mliqe_checker u_mliqe_checker (.*);
`default_nettype wire
